// File: rtl/atgs_pkg.sv
// -----------------------------------------------------------------------------
// atgs_pkg: shared types and constants
// Table sizes, field widths, datapath opcodes and the command and status
// words between the controller and the datapath.
// -----------------------------------------------------------------------------
package atgs_pkg;

	localparam int MAX_TOPICS  = 64;
	localparam int TOPIC_W     = 6;
	localparam int WORD_W      = 12;
	localparam int AUTHOR_W    = 8;
	localparam int N_AUTH      = 4;
	localparam int LIST_W      = 2;
	localparam int CNT_IN_W    = 3;
	localparam int COUNT_W     = 20;
	localparam int TOTAL_W     = 24;
	localparam int CUM_W       = 40;
	localparam int FRAC_W      = 32;
	localparam int DIV_W       = 42;
	localparam int PRIOR_W     = 24;
	localparam int K_W         = 7;
	localparam int V_W         = 13;
	localparam int U_W         = 16;
	localparam int CFG_DATA_W  = 24;
	localparam int CFG_IDX_W   = 2;
	localparam int WT_ADDR_W   = WORD_W + TOPIC_W;
	localparam int AT_ADDR_W   = AUTHOR_W + TOPIC_W;
	localparam int CUM_ADDR_W  = LIST_W + TOPIC_W;
	localparam int CLR_W       = WT_ADDR_W;
	localparam int VB_W        = V_W + PRIOR_W;
	localparam int KA_W        = K_W + PRIOR_W;

	localparam logic [K_W-1:0]     TOPICS_RST = K_W'(64);
	localparam logic [V_W-1:0]     VOCAB_RST  = V_W'(4096);
	localparam logic [PRIOR_W-1:0] ALPHA_RST  = PRIOR_W'(32768);
	localparam logic [PRIOR_W-1:0] BETA_RST   = PRIOR_W'(6554);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TOPICS,
		REG_VOCAB,
		REG_ALPHA,
		REG_BETA
	} cfg_reg_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_CLEAR,
		OP_CAPTURE,
		OP_READ,
		OP_DEC,
		OP_INC,
		OP_DIVW,
		OP_DIVA,
		OP_MUL,
		OP_ACC,
		OP_THR,
		OP_SCAN,
		OP_CMP
	} dp_op_t;

	typedef enum logic [1:0] {
		PAIR_OLD,
		PAIR_LIST,
		PAIR_PICK
	} pair_t;

	typedef struct packed {
		dp_op_t              op;
		pair_t               pair;
		logic [LIST_W-1:0]   idx_i;
		logic [TOPIC_W-1:0]  idx_k;
		logic [CLR_W-1:0]    clr_addr;
	} dp_cmd_t;

	typedef struct packed {
		logic                is_sample;
		logic [LIST_W-1:0]   n_m1;
		logic [TOPIC_W-1:0]  k_m1;
		logic                div_done;
		logic                hit;
	} dp_stat_t;

endpackage

// File: rtl/atgs_div.sv
// -----------------------------------------------------------------------------
// atgs_div: restoring fraction divider
// num/den with 32 fraction bits, one quotient bit a cycle; all ones when
// num is not below den.
// -----------------------------------------------------------------------------
module atgs_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [atgs_pkg::DIV_W-1:0]        num,
	input  logic [atgs_pkg::DIV_W-1:0]        den,
	output logic                              done,
	output logic [atgs_pkg::FRAC_W-1:0]       quo
);

	logic [atgs_pkg::DIV_W-1:0]  r_q;
	logic [atgs_pkg::DIV_W-1:0]  den_q;
	logic [atgs_pkg::FRAC_W-1:0] q_q;
	logic [4:0]                  cnt_q;
	logic                        run_q;
	logic                        sat_q;
	logic                        done_q;
	logic [atgs_pkg::DIV_W:0]    shifted;

	assign shifted = {r_q, 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			r_q   <= num;
			den_q <= den;
			q_q   <= '0;
			sat_q <= (num >= den);
		end else if (run_q) begin
			if (shifted >= {1'b0, den_q}) begin
				r_q <= atgs_pkg::DIV_W'(shifted - {1'b0, den_q});
				q_q <= {q_q[atgs_pkg::FRAC_W-2:0], 1'b1};
			end else begin
				r_q <= shifted[atgs_pkg::DIV_W-1:0];
				q_q <= {q_q[atgs_pkg::FRAC_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quo  = sat_q ? '1 : q_q;

endmodule

// File: rtl/atgs_dp.sv
// -----------------------------------------------------------------------------
// atgs_dp: sampler datapath
// Count tables, config registers, weight arithmetic, running sum, draw and
// scan compare. Acts on one command per cycle from the controller.
// -----------------------------------------------------------------------------
module atgs_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  atgs_pkg::dp_cmd_t                   cmd,
	output atgs_pkg::dp_stat_t                  stat,
	input  logic                                cfg_we,
	input  logic [atgs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [atgs_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                command,
	input  logic [atgs_pkg::WORD_W-1:0]         word,
	input  logic [atgs_pkg::TOPIC_W-1:0]        old_topic,
	input  logic [atgs_pkg::AUTHOR_W-1:0]       old_author,
	input  logic [atgs_pkg::CNT_IN_W-1:0]       author_count,
	input  logic [atgs_pkg::AUTHOR_W-1:0]       author_0,
	input  logic [atgs_pkg::AUTHOR_W-1:0]       author_1,
	input  logic [atgs_pkg::AUTHOR_W-1:0]       author_2,
	input  logic [atgs_pkg::AUTHOR_W-1:0]       author_3,
	input  logic [atgs_pkg::U_W-1:0]            uniform_draw,
	output logic [atgs_pkg::TOPIC_W-1:0]        new_topic,
	output logic [atgs_pkg::AUTHOR_W-1:0]       new_author,
	output logic                                status
);

	// config
	logic [atgs_pkg::K_W-1:0]     topics_q;
	logic [atgs_pkg::V_W-1:0]     vocab_q;
	logic [atgs_pkg::PRIOR_W-1:0] alpha_q;
	logic [atgs_pkg::PRIOR_W-1:0] beta_q;

	// captured word
	logic                         is_sample_q;
	logic [atgs_pkg::WORD_W-1:0]  word_q;
	logic [atgs_pkg::TOPIC_W-1:0] k0_q;
	logic [atgs_pkg::AUTHOR_W-1:0] a0_q;
	logic [atgs_pkg::AUTHOR_W-1:0] list_q [atgs_pkg::N_AUTH];
	logic [atgs_pkg::LIST_W-1:0]  n_m1_q;
	logic [atgs_pkg::TOPIC_W-1:0] k_m1_q;
	logic [atgs_pkg::U_W-1:0]     u_q;
	logic [atgs_pkg::VB_W-1:0]    vb_q;
	logic [atgs_pkg::KA_W-1:0]    ka_q;

	logic [atgs_pkg::LIST_W-1:0]  n_m1_d;
	logic [atgs_pkg::TOPIC_W-1:0] k_m1_d;

	// tables
	logic [atgs_pkg::COUNT_W-1:0] wt_mem [2**atgs_pkg::WT_ADDR_W];
	logic [atgs_pkg::COUNT_W-1:0] at_mem [2**atgs_pkg::AT_ADDR_W];
	logic [atgs_pkg::TOTAL_W-1:0] tt_mem [2**atgs_pkg::TOPIC_W];
	logic [atgs_pkg::TOTAL_W-1:0] as_mem [2**atgs_pkg::AUTHOR_W];
	logic [atgs_pkg::CUM_W-1:0]   cum_mem [2**atgs_pkg::CUM_ADDR_W];

	logic [atgs_pkg::COUNT_W-1:0] wt_rd, at_rd;
	logic [atgs_pkg::TOTAL_W-1:0] tt_rd, as_rd;
	logic [atgs_pkg::CUM_W-1:0]   cum_rd;

	logic [atgs_pkg::TOPIC_W-1:0]  sel_k, tk_q;
	logic [atgs_pkg::AUTHOR_W-1:0] sel_a, ta_q;

	logic                          upd, inc;
	logic [atgs_pkg::COUNT_W-1:0]  wt_new, at_new;
	logic [atgs_pkg::TOTAL_W-1:0]  tt_new, as_new;
	logic [3:0]                    lim;

	// arithmetic
	logic [atgs_pkg::DIV_W-1:0]   wnum, wden, anum, aden, anum_q, aden_q;
	logic [atgs_pkg::DIV_W-1:0]   div_num, div_den;
	logic                         div_start, div_done;
	logic [atgs_pkg::FRAC_W-1:0]  div_q, f1_q;
	logic [2*atgs_pkg::FRAC_W-1:0] prod_q;
	logic [atgs_pkg::CUM_W:0]     sum;
	logic [atgs_pkg::CUM_W-1:0]   run_q, thr_q;
	logic [atgs_pkg::CUM_W+atgs_pkg::U_W-1:0] thr_full;
	logic                         hit;
	logic [atgs_pkg::CUM_ADDR_W-1:0] cum_addr;

	logic [atgs_pkg::TOPIC_W-1:0]  pick_k_q;
	logic [atgs_pkg::AUTHOR_W-1:0] pick_a_q;
	logic                          flag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			topics_q <= atgs_pkg::TOPICS_RST;
			vocab_q  <= atgs_pkg::VOCAB_RST;
			alpha_q  <= atgs_pkg::ALPHA_RST;
			beta_q   <= atgs_pkg::BETA_RST;
		end else if (cfg_we) begin
			case (atgs_pkg::cfg_reg_t'(cfg_index))
				atgs_pkg::REG_TOPICS: topics_q <= cfg_data[atgs_pkg::K_W-1:0];
				atgs_pkg::REG_VOCAB:  vocab_q  <= cfg_data[atgs_pkg::V_W-1:0];
				atgs_pkg::REG_ALPHA:  alpha_q  <= cfg_data;
				atgs_pkg::REG_BETA:   beta_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// list length and topic count, clamped
	always_comb begin
		if (author_count == '0)
			n_m1_d = '0;
		else if (author_count > atgs_pkg::CNT_IN_W'(atgs_pkg::N_AUTH))
			n_m1_d = atgs_pkg::LIST_W'(atgs_pkg::N_AUTH - 1);
		else
			n_m1_d = atgs_pkg::LIST_W'(author_count - 3'd1);
		if (topics_q == '0)
			k_m1_d = '0;
		else if (topics_q > atgs_pkg::K_W'(atgs_pkg::MAX_TOPICS))
			k_m1_d = atgs_pkg::TOPIC_W'(atgs_pkg::MAX_TOPICS - 1);
		else
			k_m1_d = atgs_pkg::TOPIC_W'(topics_q - 7'd1);
	end

	always_comb begin
		case (cmd.pair)
			atgs_pkg::PAIR_LIST: begin
				sel_k = cmd.idx_k;
				sel_a = list_q[cmd.idx_i];
			end
			atgs_pkg::PAIR_PICK: begin
				sel_k = pick_k_q;
				sel_a = pick_a_q;
			end
			default: begin
				sel_k = k0_q;
				sel_a = a0_q;
			end
		endcase
	end

	// saturating count update
	assign upd = (cmd.op == atgs_pkg::OP_INC) || (cmd.op == atgs_pkg::OP_DEC);
	assign inc = (cmd.op == atgs_pkg::OP_INC);
	always_comb begin
		lim[0] = inc ? (wt_rd == '1) : (wt_rd == '0);
		lim[1] = inc ? (at_rd == '1) : (at_rd == '0);
		lim[2] = inc ? (tt_rd == '1) : (tt_rd == '0);
		lim[3] = inc ? (as_rd == '1) : (as_rd == '0);
		wt_new = lim[0] ? wt_rd : (inc ? wt_rd + 1'b1 : wt_rd - 1'b1);
		at_new = lim[1] ? at_rd : (inc ? at_rd + 1'b1 : at_rd - 1'b1);
		tt_new = lim[2] ? tt_rd : (inc ? tt_rd + 1'b1 : tt_rd - 1'b1);
		as_new = lim[3] ? as_rd : (inc ? as_rd + 1'b1 : as_rd - 1'b1);
	end

	always_ff @(posedge clk) begin
		if (cmd.op == atgs_pkg::OP_CLEAR) begin
			wt_mem[cmd.clr_addr] <= '0;
			at_mem[cmd.clr_addr[atgs_pkg::AT_ADDR_W-1:0]] <= '0;
			tt_mem[cmd.clr_addr[atgs_pkg::TOPIC_W-1:0]] <= '0;
			as_mem[cmd.clr_addr[atgs_pkg::AUTHOR_W-1:0]] <= '0;
		end else if (upd) begin
			wt_mem[{word_q, tk_q}] <= wt_new;
			at_mem[{ta_q, tk_q}]   <= at_new;
			tt_mem[tk_q]           <= tt_new;
			as_mem[ta_q]           <= as_new;
		end
		if (cmd.op == atgs_pkg::OP_READ) begin
			wt_rd <= wt_mem[{word_q, sel_k}];
			at_rd <= at_mem[{sel_a, sel_k}];
			tt_rd <= tt_mem[sel_k];
			as_rd <= as_mem[sel_a];
			tk_q  <= sel_k;
			ta_q  <= sel_a;
		end
	end

	// weight factors
	assign wnum = atgs_pkg::DIV_W'({wt_rd, 16'h0}) + atgs_pkg::DIV_W'(beta_q);
	assign wden = atgs_pkg::DIV_W'({tt_rd, 16'h0}) + atgs_pkg::DIV_W'(vb_q);
	assign anum = atgs_pkg::DIV_W'({at_rd, 16'h0}) + atgs_pkg::DIV_W'(alpha_q);
	assign aden = atgs_pkg::DIV_W'({as_rd, 16'h0}) + atgs_pkg::DIV_W'(ka_q);

	assign div_start = (cmd.op == atgs_pkg::OP_DIVW) || (cmd.op == atgs_pkg::OP_DIVA);
	assign div_num   = (cmd.op == atgs_pkg::OP_DIVA) ? anum_q : wnum;
	assign div_den   = (cmd.op == atgs_pkg::OP_DIVA) ? aden_q : wden;

	atgs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_q)
	);

	assign sum      = {1'b0, run_q} + (atgs_pkg::CUM_W + 1)'(prod_q[2*atgs_pkg::FRAC_W-1:atgs_pkg::FRAC_W]);
	assign thr_full = run_q * u_q;
	assign cum_addr = {cmd.idx_i, cmd.idx_k};
	assign hit      = (cum_rd > thr_q);

	always_ff @(posedge clk) begin
		case (cmd.op)
			atgs_pkg::OP_CAPTURE: begin
				is_sample_q <= command;
				word_q      <= word;
				k0_q        <= old_topic;
				a0_q        <= old_author;
				list_q[0]   <= author_0;
				list_q[1]   <= author_1;
				list_q[2]   <= author_2;
				list_q[3]   <= author_3;
				n_m1_q      <= n_m1_d;
				k_m1_q      <= k_m1_d;
				u_q         <= uniform_draw;
				vb_q        <= vocab_q * beta_q;
				ka_q        <= ({1'b0, k_m1_d} + 7'd1) * alpha_q;
				pick_k_q    <= old_topic;
				pick_a_q    <= old_author;
				run_q       <= '0;
				flag_q      <= 1'b0;
			end
			atgs_pkg::OP_DEC, atgs_pkg::OP_INC: begin
				if (|lim)
					flag_q <= 1'b1;
			end
			atgs_pkg::OP_DIVW: begin
				anum_q <= anum;
				aden_q <= aden;
			end
			atgs_pkg::OP_DIVA: f1_q <= div_q;
			atgs_pkg::OP_MUL:  prod_q <= f1_q * div_q;
			atgs_pkg::OP_ACC: begin
				run_q <= sum[atgs_pkg::CUM_W] ? '1 : sum[atgs_pkg::CUM_W-1:0];
				cum_mem[cum_addr] <= sum[atgs_pkg::CUM_W] ? '1 : sum[atgs_pkg::CUM_W-1:0];
			end
			atgs_pkg::OP_THR: begin
				thr_q    <= thr_full[atgs_pkg::CUM_W+atgs_pkg::U_W-1:atgs_pkg::U_W];
				pick_k_q <= k_m1_q;
				pick_a_q <= list_q[n_m1_q];
			end
			atgs_pkg::OP_SCAN: cum_rd <= cum_mem[cum_addr];
			atgs_pkg::OP_CMP: begin
				if (hit) begin
					pick_k_q <= cmd.idx_k;
					pick_a_q <= list_q[cmd.idx_i];
				end
			end
			default: ;
		endcase
	end

	assign stat.is_sample = is_sample_q;
	assign stat.n_m1      = n_m1_q;
	assign stat.k_m1      = k_m1_q;
	assign stat.div_done  = div_done;
	assign stat.hit       = hit;

	assign new_topic  = pick_k_q;
	assign new_author = pick_a_q;
	assign status     = flag_q;

endmodule

// File: rtl/atgs_ctrl.sv
// -----------------------------------------------------------------------------
// atgs_ctrl: sampler sequencer
// Clearing sweep after reset, then per word: add counts in; resample removes,
// weighs every (author, topic), draws, scans, counts back in; both strobe done.
// -----------------------------------------------------------------------------
module atgs_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	output logic                 done,
	output atgs_pkg::dp_cmd_t    cmd,
	input  atgs_pkg::dp_stat_t   stat
);

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_RD_OLD, S_UPD_OLD, S_W_RD, S_DIV_W, S_WAIT_W,
		S_DIV_A, S_WAIT_A, S_MUL, S_ACC, S_THR, S_SC_RD, S_SC_CMP,
		S_RD_NEW, S_UPD_NEW
	} state_t;

	state_t                        state_q;
	logic [atgs_pkg::LIST_W-1:0]   i_q;
	logic [atgs_pkg::TOPIC_W-1:0]  k_q;
	logic [atgs_pkg::CLR_W-1:0]    clr_q;
	logic                          done_q;
	logic                          last;

	assign last = (i_q == stat.n_m1) && (k_q == stat.k_m1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			i_q     <= '0;
			k_q     <= '0;
			clr_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1)
						state_q <= S_IDLE;
				end
				S_IDLE:    if (start) state_q <= S_RD_OLD;
				S_RD_OLD:  state_q <= S_UPD_OLD;
				S_UPD_OLD: begin
					i_q <= '0;
					k_q <= '0;
					if (stat.is_sample) begin
						state_q <= S_W_RD;
					end else begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_W_RD:   state_q <= S_DIV_W;
				S_DIV_W:  state_q <= S_WAIT_W;
				S_WAIT_W: if (stat.div_done) state_q <= S_DIV_A;
				S_DIV_A:  state_q <= S_WAIT_A;
				S_WAIT_A: if (stat.div_done) state_q <= S_MUL;
				S_MUL:    state_q <= S_ACC;
				S_ACC: begin
					if (last) begin
						state_q <= S_THR;
					end else begin
						state_q <= S_W_RD;
						if (k_q == stat.k_m1) begin
							k_q <= '0;
							i_q <= i_q + 1'b1;
						end else begin
							k_q <= k_q + 1'b1;
						end
					end
				end
				S_THR: begin
					i_q     <= '0;
					k_q     <= '0;
					state_q <= S_SC_RD;
				end
				S_SC_RD:  state_q <= S_SC_CMP;
				S_SC_CMP: begin
					if (stat.hit || last) begin
						state_q <= S_RD_NEW;
					end else begin
						state_q <= S_SC_RD;
						if (k_q == stat.k_m1) begin
							k_q <= '0;
							i_q <= i_q + 1'b1;
						end else begin
							k_q <= k_q + 1'b1;
						end
					end
				end
				S_RD_NEW:  state_q <= S_UPD_NEW;
				S_UPD_NEW: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd.op       = atgs_pkg::OP_NOP;
		cmd.pair     = atgs_pkg::PAIR_LIST;
		cmd.idx_i    = i_q;
		cmd.idx_k    = k_q;
		cmd.clr_addr = clr_q;
		case (state_q)
			S_CLEAR:   cmd.op = atgs_pkg::OP_CLEAR;
			S_IDLE:    if (start) cmd.op = atgs_pkg::OP_CAPTURE;
			S_RD_OLD: begin
				cmd.op   = atgs_pkg::OP_READ;
				cmd.pair = atgs_pkg::PAIR_OLD;
			end
			S_UPD_OLD: cmd.op = stat.is_sample ? atgs_pkg::OP_DEC : atgs_pkg::OP_INC;
			S_W_RD:    cmd.op = atgs_pkg::OP_READ;
			S_DIV_W:   cmd.op = atgs_pkg::OP_DIVW;
			S_DIV_A:   cmd.op = atgs_pkg::OP_DIVA;
			S_MUL:     cmd.op = atgs_pkg::OP_MUL;
			S_ACC:     cmd.op = atgs_pkg::OP_ACC;
			S_THR:     cmd.op = atgs_pkg::OP_THR;
			S_SC_RD:   cmd.op = atgs_pkg::OP_SCAN;
			S_SC_CMP:  cmd.op = atgs_pkg::OP_CMP;
			S_RD_NEW: begin
				cmd.op   = atgs_pkg::OP_READ;
				cmd.pair = atgs_pkg::PAIR_PICK;
			end
			S_UPD_NEW: cmd.op = atgs_pkg::OP_INC;
			default:   cmd.op = atgs_pkg::OP_NOP;
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

endmodule

// File: rtl/author_topic_gibbs_sampler.sv
// -----------------------------------------------------------------------------
// author_topic_gibbs_sampler: author-topic collapsed Gibbs sampler
// Keeps word-topic, author-topic and total counts; counts tokens in and
// resamples a token's (topic, author) pair one word at a time.
// -----------------------------------------------------------------------------
//
// channel   signals                                   direction  handshake
// input     command word old_topic old_author          in         start & !busy
//           author_count author_0..3 uniform_draw
// result    new_topic new_author status                out        done strobe
// config    cfg_we cfg_index cfg_data                  in         cfg_we
//
// An add word passes through a read state and an update state; done is
// registered out of the update state. A resample word weighs every (author,
// topic) pair with the shared 32-step divider, used twice per weight, then
// scans the stored running sums; the scan stops at the first hit.
// After reset a clearing sweep over all 262144 word-topic addresses zeroes the
// count tables; busy stays high through it. The receiver cannot stall: each
// result is on the ports when done is high and holds until the next word is
// accepted.
// -----------------------------------------------------------------------------
module author_topic_gibbs_sampler (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	output logic                                done,
	input  logic                                cfg_we,
	input  logic [atgs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [atgs_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                command,
	input  logic [atgs_pkg::WORD_W-1:0]         word,
	input  logic [atgs_pkg::TOPIC_W-1:0]        old_topic,
	input  logic [atgs_pkg::AUTHOR_W-1:0]       old_author,
	input  logic [atgs_pkg::CNT_IN_W-1:0]       author_count,
	input  logic [atgs_pkg::AUTHOR_W-1:0]       author_0,
	input  logic [atgs_pkg::AUTHOR_W-1:0]       author_1,
	input  logic [atgs_pkg::AUTHOR_W-1:0]       author_2,
	input  logic [atgs_pkg::AUTHOR_W-1:0]       author_3,
	input  logic [atgs_pkg::U_W-1:0]            uniform_draw,
	output logic [atgs_pkg::TOPIC_W-1:0]        new_topic,
	output logic [atgs_pkg::AUTHOR_W-1:0]       new_author,
	output logic                                status
);

	// controller <-> datapath: one command word down, one status word up
	atgs_pkg::dp_cmd_t  cmd;
	atgs_pkg::dp_stat_t stat;

	atgs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd),
		.stat   (stat)
	);

	// tables, divider, running sum and draw all live here
	atgs_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.command      (command),
		.word         (word),
		.old_topic    (old_topic),
		.old_author   (old_author),
		.author_count (author_count),
		.author_0     (author_0),
		.author_1     (author_1),
		.author_2     (author_2),
		.author_3     (author_3),
		.uniform_draw (uniform_draw),
		.new_topic    (new_topic),
		.new_author   (new_author),
		.status       (status)
	);

	// a result strobe always lands with the sequencer back at idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobed while sequencer busy");

	// an accepted word always makes the sequencer busy next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted word did not start work");

	// one strobe per word
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held over two cycles");

endmodule
